/* rtl/tlcs_pkg.sv */
// Shared types and constants for the two-level cache stall model.
package tlcs_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVELS      = 3'd0,
		REG_MEM_LATENCY = 3'd1,
		REG_L2_LATENCY  = 3'd2,
		REG_L1_USE_LRU  = 3'd3,
		REG_L1_WB       = 3'd4,
		REG_L2_USE_LRU  = 3'd5,
		REG_L2_WB       = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_FETCH = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_STORE = 2'd2
	} cmd_code_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] addr;
	} req_t;

	typedef struct packed {
		logic [13:0] stall_cycles;
		logic        l1_hit;
		logic        l2_looked_up;
		logic        l2_hit;
		logic        l1_dirty_evicted;
		logic        l2_dirty_evicted;
		logic [31:0] l1_hit_total;
		logic [31:0] l1_miss_total;
		logic [31:0] l2_hit_total;
		logic [31:0] l2_miss_total;
	} resp_t;

	typedef struct packed {
		logic [1:0]  levels;
		logic [11:0] mem_latency;
		logic [7:0]  l2_latency;
		logic        l1_use_lru;
		logic        l1_write_back;
		logic        l2_use_lru;
		logic        l2_write_back;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;  // capture request, read L1 set
		logic l1_upd;    // resolve and write back L1 set
		logic l2_rd;     // read L2 set
		logic l2_upd;    // resolve and write back L2 set
		logic finish;    // result ready; drives done
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_l2;
	} sts_t;

endpackage

/* rtl/two_level_cache_stall_model.sv */
// Top level: two-level cache stall model with config registers.
// done follows the L1 steps on an L1 hit or when levels is not 2, and follows the search
// of the shared second level on an L1 miss with two levels; busy covers the whole access,
// so a new access is accepted only once the last one has finished.
// The result is on result for the single cycle done is high; no backpressure.
// arst_n clears config to defaults, all valid state and counters.
module two_level_cache_stall_model import tlcs_pkg::*; #(
	parameter int unsigned L1_SETS = 64,
	parameter int unsigned L1_WAYS = 4,
	parameter int unsigned L1_WORDS = 8,
	parameter int unsigned L2_SETS = 256,
	parameter int unsigned L2_WAYS = 8,
	parameter int unsigned L2_WORDS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output resp_t                 result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t cfg_q;
	ctl_t ctl;
	sts_t sts;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.levels        <= 2'd1;
			cfg_q.mem_latency   <= 12'd100;
			cfg_q.l2_latency    <= 8'd10;
			cfg_q.l1_use_lru    <= 1'b1;
			cfg_q.l1_write_back <= 1'b1;
			cfg_q.l2_use_lru    <= 1'b1;
			cfg_q.l2_write_back <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LEVELS:      cfg_q.levels        <= cfg_data[1:0];
				REG_MEM_LATENCY: cfg_q.mem_latency   <= cfg_data;
				REG_L2_LATENCY:  cfg_q.l2_latency    <= cfg_data[7:0];
				REG_L1_USE_LRU:  cfg_q.l1_use_lru    <= cfg_data[0];
				REG_L1_WB:       cfg_q.l1_write_back <= cfg_data[0];
				REG_L2_USE_LRU:  cfg_q.l2_use_lru    <= cfg_data[0];
				REG_L2_WB:       cfg_q.l2_write_back <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tlcs_ctrl u_ctrl (
		.clk, .arst_n, .start, .sts, .ctl, .busy, .done);

	tlcs_datapath #(
		.L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L1_WORDS(L1_WORDS),
		.L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS), .L2_WORDS(L2_WORDS)
	) u_dp (
		.clk, .arst_n, .req, .cfg(cfg_q), .ctl, .sts, .resp(result));
endmodule

/* rtl/tlcs_level.sv */
// One set-associative tag level: tag/valid/dirty/rank memories and update logic.
module tlcs_level import tlcs_pkg::*; #(
	parameter int unsigned SETS  = 64,
	parameter int unsigned WAYS  = 4,
	parameter int unsigned WORDS = 8,
	parameter bit HAS_DIRTY = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd,
	input  logic [31:0] rd_addr,
	input  logic        upd,
	input  logic        use_lru,
	input  logic        wb,
	input  logic        store_mark,  // touch and dirty the line after a fill
	input  logic        touch_hit,   // apply LRU touch on a hit
	input  logic        mark_hit,    // apply dirty mark on a hit
	output logic        hit,
	output logic        dirty_ev
);
	localparam int unsigned OB = (WORDS > 1) ? $clog2(WORDS) : 0;
	localparam int unsigned IB = (SETS > 1) ? $clog2(SETS) : 0;
	localparam int unsigned IW = (SETS > 1) ? IB : 1;
	localparam int unsigned TW = 30 - OB - IB;
	localparam int unsigned RW = $clog2(WAYS + 1);
	localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef struct packed {
		logic          valid;
		logic          dirty;
		logic [RW-1:0] rank;
		logic [TW-1:0] tag;
	} line_t;

	// row memory, one set per row; valid bits per set handle reset
	line_t [WAYS-1:0] mem [SETS];
	logic [SETS-1:0] set_ok_q;
	line_t [WAYS-1:0] row_q;
	logic [IW-1:0]    idx_q;
	logic [TW-1:0]    tag_q;
	logic             row_ok_q;

	line_t [WAYS-1:0] row;
	line_t [WAYS-1:0] row_f;
	line_t [WAYS-1:0] row_nx;
	logic [WW-1:0] hw, fw;
	logic          hit_c, full;
	logic [RW-1:0] vcnt, r, v2;

	logic [IW-1:0] rd_idx;
	always_comb begin
		if (SETS > 1) rd_idx = IW'(rd_addr >> (2 + OB));
		else rd_idx = '0;
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			row_q <= mem[rd_idx];
			idx_q <= rd_idx;
			tag_q <= TW'(rd_addr >> (2 + OB + IB));
		end
		if (upd) mem[idx_q] <= row_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_ok_q <= '0;
			row_ok_q <= 1'b0;
		end else begin
			if (rd) row_ok_q <= set_ok_q[rd_idx];
			if (upd) set_ok_q[idx_q] <= 1'b1;
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) row[w] = row_ok_q ? row_q[w] : '0;
		hit_c = 1'b0; hw = '0;
		for (int w = WAYS - 1; w >= 0; w--)
			if (row[w].valid && row[w].tag == tag_q) begin hit_c = 1'b1; hw = WW'(w); end
		vcnt = '0;
		for (int w = 0; w < WAYS; w++) vcnt = vcnt + RW'(row[w].valid);
		full = (vcnt == RW'(WAYS));
		fw = '0;
		dirty_ev = 1'b0;
		row_f = row;
		if (!hit_c) begin
			if (!full) begin
				for (int w = WAYS - 1; w >= 0; w--)
					if (!row[w].valid) fw = WW'(w);
				row_f[fw].rank = vcnt + RW'(1);
			end else begin
				for (int w = WAYS - 1; w >= 0; w--)
					if (row[w].rank == RW'(1)) fw = WW'(w);
				for (int w = 0; w < WAYS; w++)
					if (WW'(w) != fw && row[w].rank != '0) row_f[w].rank = row[w].rank - RW'(1);
				row_f[fw].rank = RW'(WAYS);
				dirty_ev = HAS_DIRTY && wb && row[fw].dirty;
			end
			row_f[fw].valid = 1'b1;
			row_f[fw].dirty = 1'b0;
			row_f[fw].tag   = tag_q;
		end else begin
			fw = hw;
		end
		// touch/mark on the resulting line
		row_nx = row_f;
		v2 = '0;
		for (int w = 0; w < WAYS; w++) v2 = v2 + RW'(row_f[w].valid);
		r = row_f[fw].rank;
		if (use_lru && (hit_c ? touch_hit : store_mark)) begin
			for (int w = 0; w < WAYS; w++)
				if (WW'(w) != fw && row_f[w].valid && row_f[w].rank > r)
					row_nx[w].rank = row_f[w].rank - RW'(1);
			row_nx[fw].rank = v2;
		end
		if (HAS_DIRTY && wb && (hit_c ? mark_hit : store_mark)) row_nx[fw].dirty = 1'b1;
		hit = hit_c;
	end
endmodule

/* rtl/tlcs_datapath.sv */
// Datapath: request capture, instruction/data/shared tag levels, stall sum, counters.
module tlcs_datapath import tlcs_pkg::*; #(
	parameter int unsigned L1_SETS = 64,
	parameter int unsigned L1_WAYS = 4,
	parameter int unsigned L1_WORDS = 8,
	parameter int unsigned L2_SETS = 256,
	parameter int unsigned L2_WAYS = 8,
	parameter int unsigned L2_WORDS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cfg_t  cfg,
	input  ctl_t  ctl,
	output sts_t  sts,
	output resp_t resp
);
	req_t  req_q;
	logic  l1hit_q, l1ev_q, l2hit_q, l2ev_q, l2look_q;
	logic [13:0] stall_q;
	logic [31:0] cnt_q [6];

	logic inst, store, two;
	assign inst  = (req_q.cmd == CMD_FETCH);
	assign store = (req_q.cmd == CMD_STORE);
	assign two   = (cfg.levels == 2'd2);

	logic i_hit, i_ev, d_hit, d_ev, s_hit, s_ev;
	logic i_upd, d_upd, i_rd, d_rd;
	assign i_rd  = ctl.load_req && (req.cmd == CMD_FETCH);
	assign d_rd  = ctl.load_req && (req.cmd != CMD_FETCH);
	assign i_upd = ctl.l1_upd && inst;
	assign d_upd = ctl.l1_upd && !inst;

	tlcs_level #(.SETS(L1_SETS), .WAYS(L1_WAYS), .WORDS(L1_WORDS), .HAS_DIRTY(1'b0)) u_inst (
		.clk, .arst_n, .rd(i_rd), .rd_addr(req.addr), .upd(i_upd),
		.use_lru(cfg.l1_use_lru), .wb(cfg.l1_write_back),
		.store_mark(1'b1), .touch_hit(1'b1), .mark_hit(1'b0),
		.hit(i_hit), .dirty_ev(i_ev));

	tlcs_level #(.SETS(L1_SETS), .WAYS(L1_WAYS), .WORDS(L1_WORDS), .HAS_DIRTY(1'b1)) u_data (
		.clk, .arst_n, .rd(d_rd), .rd_addr(req.addr), .upd(d_upd),
		.use_lru(cfg.l1_use_lru), .wb(cfg.l1_write_back),
		.store_mark(store), .touch_hit(1'b1), .mark_hit(store),
		.hit(d_hit), .dirty_ev(d_ev));

	// a fill already leaves the new line newest, so the touch after a fill changes
	// nothing; store_mark only has to carry the dirty mark of a store
	logic l1_hit_c, l1_ev_c;
	assign l1_hit_c = inst ? i_hit : d_hit;
	assign l1_ev_c  = inst ? i_ev : d_ev;

	logic s_mark;
	assign s_mark = store && !cfg.l1_write_back;
	tlcs_level #(.SETS(L2_SETS), .WAYS(L2_WAYS), .WORDS(L2_WORDS), .HAS_DIRTY(1'b1)) u_shared (
		.clk, .arst_n, .rd(ctl.l2_rd), .rd_addr(req_q.addr), .upd(ctl.l2_upd),
		.use_lru(cfg.l2_use_lru), .wb(cfg.l2_write_back),
		.store_mark(s_mark), .touch_hit(1'b1), .mark_hit(store),
		.hit(s_hit), .dirty_ev(s_ev));

	assign sts.need_l2 = !l1hit_q && two;

	logic [13:0] base;
	always_comb begin
		base = 14'(l1_ev_c ? cfg.mem_latency : 12'd0);
		if (!l1_hit_c && !two) base = base + 14'(cfg.mem_latency);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) req_q <= req;
		if (ctl.l1_upd) begin
			l1hit_q <= l1_hit_c;
			l1ev_q  <= l1_ev_c;
			stall_q <= l1_hit_c ? 14'd0 : base;
			l2look_q <= 1'b0; l2hit_q <= 1'b0; l2ev_q <= 1'b0;
		end
		if (ctl.l2_upd) begin
			l2look_q <= 1'b1;
			l2hit_q  <= s_hit;
			l2ev_q   <= !s_hit && s_ev;
			stall_q  <= stall_q + 14'(cfg.l2_latency)
				+ (s_hit ? 14'd0 : 14'(cfg.mem_latency)
				   + ((s_ev) ? 14'(cfg.mem_latency) : 14'd0)
				   + (s_mark ? 14'(cfg.l2_latency) : 14'd0));
		end
	end

	logic [2:0] hc;
	assign hc = inst ? 3'd0 : 3'd2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) cnt_q[i] <= '0;
		end else begin
			if (ctl.l1_upd) begin
				if (l1_hit_c) cnt_q[hc] <= cnt_q[hc] + 32'd1;
				else cnt_q[hc + 3'd1] <= cnt_q[hc + 3'd1] + 32'd1;
			end
			if (ctl.l2_upd) begin
				if (s_hit) cnt_q[4] <= cnt_q[4] + 32'd1;
				else cnt_q[5] <= cnt_q[5] + 32'd1;
			end
		end
	end

	always_comb begin
		resp.stall_cycles     = stall_q;
		resp.l1_hit           = l1hit_q;
		resp.l2_looked_up     = l2look_q;
		resp.l2_hit           = l2hit_q;
		resp.l1_dirty_evicted = l1ev_q;
		resp.l2_dirty_evicted = l2ev_q;
		resp.l1_hit_total     = cnt_q[hc];
		resp.l1_miss_total    = cnt_q[hc + 3'd1];
		resp.l2_hit_total     = cnt_q[4];
		resp.l2_miss_total    = cnt_q[5];
	end
endmodule

/* rtl/tlcs_ctrl.sv */
// Controller state machine sequencing L1 then L2 work for one access.
module tlcs_ctrl import tlcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy,
	output logic done
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_L1   = 5'b00010,
		ST_L2RD = 5'b00100,
		ST_L2   = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin ctl.load_req = 1'b1; state_nx = ST_L1; end
			end
			ST_L1: begin
				ctl.l1_upd = 1'b1; state_nx = ST_L2RD;
			end
			ST_L2RD: begin
				if (sts.need_l2) begin ctl.l2_rd = 1'b1; state_nx = ST_L2; end
				else state_nx = ST_DONE;
			end
			ST_L2: begin
				ctl.l2_upd = 1'b1; state_nx = ST_DONE;
			end
			ST_DONE: begin
				ctl.finish = 1'b1; state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = ctl.finish;
endmodule

/* tb/sv/tb_two_level_cache_stall_model.sv */
`timescale 1ns / 100ps
// Testbench for the two-level cache stall model: directed table, random accesses, predictor.
module tb_two_level_cache_stall_model;
	import tlcs_pkg::*;

	localparam int unsigned L1_SETS = 64, L1_WAYS = 4, L1_OBITS = 3, L1_IBITS = 6;
	localparam int unsigned L2_SETS = 256, L2_WAYS = 8, L2_OBITS = 3, L2_IBITS = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	resp_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	two_level_cache_stall_model dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: split first level, shared second level, six counters.
	logic [31:0] itag [L1_SETS*L1_WAYS];
	logic        ival [L1_SETS*L1_WAYS];
	logic [4:0]  irank [L1_SETS*L1_WAYS];
	logic [31:0] dtag [L1_SETS*L1_WAYS];
	logic        dval [L1_SETS*L1_WAYS];
	logic        ddirty [L1_SETS*L1_WAYS];
	logic [4:0]  drank [L1_SETS*L1_WAYS];
	logic [31:0] stag [L2_SETS*L2_WAYS];
	logic        sval [L2_SETS*L2_WAYS];
	logic        sdirty [L2_SETS*L2_WAYS];
	logic [4:0]  srank [L2_SETS*L2_WAYS];
	logic [31:0] access_count [6];
	cfg_t        mdl_cfg;

	resp_t pending_q[$];
	int unsigned error_count = 0;
	int unsigned checked_count = 0;
	int unsigned stall_window = 0;
	int unsigned sent_count = 0;
	bit          gaps_on = 1'b1;

	// Per-level views: lvl 0 instruction, 1 data, 2 shared.
	function automatic int unsigned lvl_ways(int lvl);
		return (lvl == 2) ? L2_WAYS : L1_WAYS;
	endfunction

	function automatic int unsigned lvl_base(int lvl, logic [31:0] a);
		if (lvl == 2)
			return ((a >> (2 + L2_OBITS)) & (L2_SETS - 1)) * L2_WAYS;
		return ((a >> (2 + L1_OBITS)) & (L1_SETS - 1)) * L1_WAYS;
	endfunction

	function automatic logic [31:0] lvl_tag(int lvl, logic [31:0] a);
		if (lvl == 2)
			return a >> (2 + L2_OBITS + L2_IBITS);
		return a >> (2 + L1_OBITS + L1_IBITS);
	endfunction

	function automatic logic get_val(int lvl, int unsigned i);
		case (lvl)
			0: return ival[i];
			1: return dval[i];
			default: return sval[i];
		endcase
	endfunction

	function automatic logic [4:0] get_rank(int lvl, int unsigned i);
		case (lvl)
			0: return irank[i];
			1: return drank[i];
			default: return srank[i];
		endcase
	endfunction

	function automatic void put_rank(int lvl, int unsigned i, logic [4:0] r);
		case (lvl)
			0: irank[i] = r;
			1: drank[i] = r;
			default: srank[i] = r;
		endcase
	endfunction

	function automatic logic get_dirty(int lvl, int unsigned i);
		case (lvl)
			0: return 1'b0;
			1: return ddirty[i];
			default: return sdirty[i];
		endcase
	endfunction

	function automatic void put_dirty(int lvl, int unsigned i, logic d);
		if (lvl == 1) ddirty[i] = d;
		else if (lvl == 2) sdirty[i] = d;
	endfunction

	function automatic bit find_line(int lvl, logic [31:0] a, output int unsigned line);
		int unsigned b;
		b = lvl_base(lvl, a);
		line = 0;
		for (int w = 0; w < lvl_ways(lvl); w++) begin
			if (get_val(lvl, b + w) &&
			    ((lvl == 0) ? itag[b+w] : (lvl == 1) ? dtag[b+w] : stag[b+w])
			    == lvl_tag(lvl, a)) begin
				line = b + w;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic int unsigned live_ways(int lvl, int unsigned b);
		int unsigned v;
		v = 0;
		for (int w = 0; w < lvl_ways(lvl); w++)
			if (get_val(lvl, b + w)) v++;
		return v;
	endfunction

	// Make a line newest under LRU.
	function automatic void refresh_age(int lvl, int unsigned line, logic lru);
		int unsigned b, v;
		logic [4:0] r;
		if (!lru) return;
		b = (line / lvl_ways(lvl)) * lvl_ways(lvl);
		v = live_ways(lvl, b);
		r = get_rank(lvl, line);
		for (int w = 0; w < lvl_ways(lvl); w++)
			if (b + w != line && get_val(lvl, b + w) && get_rank(lvl, b + w) > r)
				put_rank(lvl, b + w, 5'(get_rank(lvl, b + w) - 5'd1));
		put_rank(lvl, line, v[4:0]);
	endfunction

	// Allocate a line; return the writeback stall of a dirty victim.
	function automatic int unsigned allocate(int lvl, logic [31:0] a, logic wb,
			output int unsigned line, output logic dirty_ev);
		int unsigned b, victim, st;
		b = lvl_base(lvl, a);
		victim = lvl_ways(lvl);
		st = 0;
		dirty_ev = 1'b0;
		for (int w = 0; w < lvl_ways(lvl); w++)
			if (!get_val(lvl, b + w)) begin
				victim = w;
				break;
			end
		if (victim < lvl_ways(lvl)) begin
			put_rank(lvl, b + victim, 5'(live_ways(lvl, b) + 1));
		end else begin
			victim = 0;
			for (int w = 0; w < lvl_ways(lvl); w++)
				if (get_rank(lvl, b + w) == 1) begin
					victim = w;
					break;
				end
			for (int w = 0; w < lvl_ways(lvl); w++)
				if (w != victim && get_rank(lvl, b + w) > 0)
					put_rank(lvl, b + w, 5'(get_rank(lvl, b + w) - 5'd1));
			put_rank(lvl, b + victim, 5'(lvl_ways(lvl)));
			if (wb && get_dirty(lvl, b + victim)) begin
				st = mdl_cfg.mem_latency;
				dirty_ev = 1'b1;
			end
		end
		line = b + victim;
		put_dirty(lvl, line, 1'b0);
		case (lvl)
			0: begin ival[line] = 1'b1; itag[line] = lvl_tag(lvl, a); end
			1: begin dval[line] = 1'b1; dtag[line] = lvl_tag(lvl, a); end
			default: begin sval[line] = 1'b1; stag[line] = lvl_tag(lvl, a); end
		endcase
		return st;
	endfunction

	function automatic resp_t predict_access(req_t r);
		resp_t o;
		int lv;
		int unsigned hc, st, line, line2;
		logic is_store, ev1, ev2;
		o = '0;
		lv = (r.cmd == CMD_FETCH) ? 0 : 1;
		hc = (lv == 0) ? 0 : 2;
		is_store = (r.cmd == CMD_STORE);
		st = 0;
		ev1 = 1'b0;
		ev2 = 1'b0;
		if (find_line(lv, r.addr, line)) begin
			o.l1_hit = 1'b1;
			access_count[hc]++;
		end else begin
			access_count[hc+1]++;
			if (mdl_cfg.levels != 2) begin
				st += mdl_cfg.mem_latency;
				st += allocate(lv, r.addr, mdl_cfg.l1_write_back, line, ev1);
			end else begin
				o.l2_looked_up = 1'b1;
				st += mdl_cfg.l2_latency;
				if (find_line(2, r.addr, line2)) begin
					o.l2_hit = 1'b1;
					access_count[4]++;
					st += allocate(lv, r.addr, mdl_cfg.l1_write_back, line, ev1);
					refresh_age(2, line2, mdl_cfg.l2_use_lru);
					if (is_store && mdl_cfg.l2_write_back) sdirty[line2] = 1'b1;
				end else begin
					access_count[5]++;
					st += mdl_cfg.mem_latency;
					st += allocate(lv, r.addr, mdl_cfg.l1_write_back, line, ev1);
					st += allocate(2, r.addr, mdl_cfg.l2_write_back, line2, ev2);
					if (is_store && !mdl_cfg.l1_write_back) begin
						st += mdl_cfg.l2_latency;
						refresh_age(2, line2, mdl_cfg.l2_use_lru);
						if (mdl_cfg.l2_write_back) sdirty[line2] = 1'b1;
					end
				end
			end
		end
		refresh_age(lv, line, mdl_cfg.l1_use_lru);
		if (is_store && mdl_cfg.l1_write_back) put_dirty(lv, line, 1'b1);
		o.stall_cycles = st[13:0];
		o.l1_dirty_evicted = ev1;
		o.l2_dirty_evicted = ev2;
		o.l1_hit_total = access_count[hc];
		o.l1_miss_total = access_count[hc+1];
		o.l2_hit_total = access_count[4];
		o.l2_miss_total = access_count[5];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	// Compare each transfer from the block against the oldest expectation.
	always @(posedge clk) begin
		resp_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_q.pop_front();
				checked_count++;
				if (result.stall_cycles !== want.stall_cycles)
					report_mismatch("stall_cycles", result.stall_cycles, want.stall_cycles);
				if (result.l1_hit !== want.l1_hit)
					report_mismatch("l1_hit", result.l1_hit, want.l1_hit);
				if (result.l2_looked_up !== want.l2_looked_up)
					report_mismatch("l2_looked_up", result.l2_looked_up, want.l2_looked_up);
				if (result.l2_hit !== want.l2_hit)
					report_mismatch("l2_hit", result.l2_hit, want.l2_hit);
				if (result.l1_dirty_evicted !== want.l1_dirty_evicted)
					report_mismatch("l1_dirty_evicted", result.l1_dirty_evicted,
						want.l1_dirty_evicted);
				if (result.l2_dirty_evicted !== want.l2_dirty_evicted)
					report_mismatch("l2_dirty_evicted", result.l2_dirty_evicted,
						want.l2_dirty_evicted);
				if (result.l1_hit_total !== want.l1_hit_total)
					report_mismatch("l1_hit_total", result.l1_hit_total, want.l1_hit_total);
				if (result.l1_miss_total !== want.l1_miss_total)
					report_mismatch("l1_miss_total", result.l1_miss_total, want.l1_miss_total);
				if (result.l2_hit_total !== want.l2_hit_total)
					report_mismatch("l2_hit_total", result.l2_hit_total, want.l2_hit_total);
				if (result.l2_miss_total !== want.l2_miss_total)
					report_mismatch("l2_miss_total", result.l2_miss_total, want.l2_miss_total);
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || cfg_we)
			stall_window <= 0;
		else
			stall_window <= stall_window + 1;
		if (stall_window >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Write one register at a falling edge; mirror it in the predictor.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LEVELS:      mdl_cfg.levels = val[1:0];
			REG_MEM_LATENCY: mdl_cfg.mem_latency = val[11:0];
			REG_L2_LATENCY:  mdl_cfg.l2_latency = val[7:0];
			REG_L1_USE_LRU:  mdl_cfg.l1_use_lru = val[0];
			REG_L1_WB:       mdl_cfg.l1_write_back = val[0];
			REG_L2_USE_LRU:  mdl_cfg.l2_use_lru = val[0];
			REG_L2_WB:       mdl_cfg.l2_write_back = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [1:0] lv, logic [11:0] mem, logic [7:0] l2l,
			logic lru1, logic wb1, logic lru2, logic wb2);
		write_reg(REG_LEVELS, CFG_DATA_W'(lv));
		write_reg(REG_MEM_LATENCY, mem);
		write_reg(REG_L2_LATENCY, CFG_DATA_W'(l2l));
		write_reg(REG_L1_USE_LRU, CFG_DATA_W'(lru1));
		write_reg(REG_L1_WB, CFG_DATA_W'(wb1));
		write_reg(REG_L2_USE_LRU, CFG_DATA_W'(lru2));
		write_reg(REG_L2_WB, CFG_DATA_W'(wb2));
	endtask

	// Drain every expectation, then let the pipeline settle.
	task automatic wait_idle();
		while (pending_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Issue one access: hold start until the block is idle again, then predict.
	task automatic issue_access(logic [1:0] cmd, logic [31:0] addr);
		req_t r;
		r.cmd = cmd;
		r.addr = addr;
		@(negedge clk);
		if (gaps_on)
			while ($urandom_range(99) < 17) @(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.push_back(predict_access(r));
		sent_count++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Address biased onto a few sets and tags so sets fill and evict.
	function automatic logic [31:0] hot_addr();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(99) < 80) begin
			a[10:5] = 6'($urandom_range(3));
			a[12:11] = 2'($urandom_range(3));
			a[31:13] = (($urandom_range(99) < 80) ? 19'd0 : a[31:13]) | 19'($urandom_range(7));
		end
		return a;
	endfunction

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] addr;
		bit          typed;
		logic [13:0] stall;
		logic        hit;
	} dir_row_t;

	dir_row_t dir_table[] = '{
		// cold miss after reset: default memory latency, one level
		'{CMD_FETCH, 32'h0000_0000, 1, 14'd100, 1'b0},
		'{CMD_FETCH, 32'h0000_0004, 1, 14'd0, 1'b1},
		'{CMD_LOAD,  32'hFFFF_FFFF, 1, 14'd100, 1'b0},
		'{CMD_STORE, 32'hFFFF_FFFC, 1, 14'd0, 1'b1},
		// unused command code acts as a load
		'{2'd3,      32'hFFFF_FFE0, 1, 14'd0, 1'b1},
		// fill one data set past capacity: LRU order keeps the touched dirty line
		'{CMD_STORE, 32'h0000_0800, 0, 14'd0, 1'b0},
		'{CMD_LOAD,  32'h0000_1000, 0, 14'd0, 1'b0},
		'{CMD_LOAD,  32'h0000_1800, 0, 14'd0, 1'b0},
		'{CMD_LOAD,  32'h0000_2000, 0, 14'd0, 1'b0},
		'{CMD_LOAD,  32'h0000_0800, 0, 14'd0, 1'b0},
		'{CMD_STORE, 32'h0000_2800, 0, 14'd0, 1'b0},
		'{CMD_LOAD,  32'h0000_3000, 0, 14'd0, 1'b0},
		'{CMD_LOAD,  32'h0000_3800, 0, 14'd0, 1'b0},
		'{CMD_FETCH, 32'hAAAA_AAAA, 0, 14'd0, 1'b0},
		'{CMD_FETCH, 32'h5555_5555, 0, 14'd0, 1'b0}
	};

	initial begin
		resp_t unused;
		mdl_cfg = '{levels: 2'd1, mem_latency: 12'd100, l2_latency: 8'd10,
			l1_use_lru: 1'b1, l1_write_back: 1'b1, l2_use_lru: 1'b1, l2_write_back: 1'b1};
		foreach (ival[i]) begin
			itag[i] = 0; ival[i] = 0; irank[i] = 0;
			dtag[i] = 0; dval[i] = 0; ddirty[i] = 0; drank[i] = 0;
		end
		foreach (sval[i]) begin
			stag[i] = 0; sval[i] = 0; sdirty[i] = 0; srank[i] = 0;
		end
		foreach (access_count[i]) access_count[i] = 0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed table under reset defaults; typed rows also checked directly.
		foreach (dir_table[i]) begin
			issue_access(dir_table[i].cmd, dir_table[i].addr);
			if (dir_table[i].typed) begin
				unused = pending_q[$];
				if (unused.stall_cycles != dir_table[i].stall)
					report_mismatch("table stall", unused.stall_cycles, dir_table[i].stall);
				if (unused.l1_hit != dir_table[i].hit)
					report_mismatch("table hit", unused.l1_hit, dir_table[i].hit);
			end
		end
		wait_idle();

		// Two levels at the latency extremes, then the other policies.
		apply_setting(2'd2, 12'd4095, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
		foreach (dir_table[i]) issue_access(dir_table[i].cmd, dir_table[i].addr);
		wait_idle();

		// Random phases walk through several settings; one runs without gaps.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_setting(2'd2, 12'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
				1: apply_setting(2'd2, 12'd37, 8'd5, 1'b1, 1'b0, 1'b0, 1'b1);
				2: apply_setting(2'd3, 12'd4095, 8'd255, 1'b0, 1'b1, 1'b1, 1'b0);
				3: apply_setting(2'd2, 12'd4095, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
				4: apply_setting(2'd0, 12'd1, 8'd1, 1'b1, 1'b1, 1'b0, 1'b0);
				5: apply_setting(2'd2, 12'd200, 8'd12, 1'b0, 1'b1, 1'b1, 1'b1);
				6: apply_setting(2'd1, 12'd4095, 8'd255, 1'b0, 1'b0, 1'b1, 1'b1);
				default: apply_setting(2'd2, 12'($urandom_range(4095)),
					8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
			endcase
			gaps_on = (ph != 3);
			repeat (RANDOM_ITEMS / 8)
				issue_access(2'($urandom_range(3)), hot_addr());
			wait_idle();
		end

		$display("covered %0d accesses, %0d results checked, over 10 register settings",
			sent_count, checked_count);
		$display("levels 1 and 2, LRU and FIFO, write back and write through, latency extremes");
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/tlcs_pkg.sv
rtl/tlcs_level.sv
rtl/tlcs_datapath.sv
rtl/tlcs_ctrl.sv
rtl/two_level_cache_stall_model.sv
tb/sv/tb_two_level_cache_stall_model.sv
